### rtl/core/sound_cpu_io_timers_block_defines.svh
// ----------------------------------------------------------------------------
// Sound CPU I/O and timers: assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SOUND_CPU_IO_TIMERS_BLOCK_DEFINES_SVH
`define SOUND_CPU_IO_TIMERS_BLOCK_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SCIO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCIO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCIO_ASSERT_NOW(label, ante, cons, msg)
`define SCIO_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/core/scio_pkg.sv
// ----------------------------------------------------------------------------
// scio_pkg
// Shared types and constants of the sound CPU I/O and timers block.
// ----------------------------------------------------------------------------
package scio_pkg;

    localparam int MEM_DEPTH   = 65536;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int TIMER_COUNT = 3;
    localparam int TIMER_IW    = $clog2(TIMER_COUNT);

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        ACT_IDLE    = 3'd0,
        ACT_CPU_RD  = 3'd1,
        ACT_CPU_WR  = 3'd2,
        ACT_HOST_WR = 3'd3,
        ACT_HOST_RD = 3'd4
    } t_action;

    localparam logic [11:0] IO_PAGE       = 12'h00F;
    localparam logic [15:0] BOOT_ROM_BASE = 16'hFFC0;

    localparam logic [3:0] REG_TEST     = 4'h0;
    localparam logic [3:0] REG_CONTROL  = 4'h1;
    localparam logic [3:0] REG_DSP_ADDR = 4'h2;
    localparam logic [3:0] REG_DSP_DATA = 4'h3;
    localparam logic [3:0] REG_PORT0    = 4'h4;
    localparam logic [3:0] REG_PORT1    = 4'h5;
    localparam logic [3:0] REG_PORT2    = 4'h6;
    localparam logic [3:0] REG_PORT3    = 4'h7;
    localparam logic [3:0] REG_AUX0     = 4'h8;
    localparam logic [3:0] REG_AUX1     = 4'h9;
    localparam logic [3:0] REG_TARGET0  = 4'hA;
    localparam logic [3:0] REG_TARGET1  = 4'hB;
    localparam logic [3:0] REG_TARGET2  = 4'hC;
    localparam logic [3:0] REG_COUNTER0 = 4'hD;
    localparam logic [3:0] REG_COUNTER1 = 4'hE;
    localparam logic [3:0] REG_COUNTER2 = 4'hF;

    // prescaler reload minus one: stage 128 for timers 0/1, stage 16 for timer 2
    localparam t_byte TIMER_RELOAD [TIMER_COUNT] = '{8'd127, 8'd127, 8'd15};

    localparam t_byte BOOT_ROM [64] = '{
        8'hcd, 8'hef, 8'hbd, 8'he8, 8'h00, 8'hc6, 8'h1d, 8'hd0,
        8'hfc, 8'h8f, 8'haa, 8'hf4, 8'h8f, 8'hbb, 8'hf5, 8'h78,
        8'hcc, 8'hf4, 8'hd0, 8'hfb, 8'h2f, 8'h19, 8'heb, 8'hf4,
        8'hd0, 8'hfc, 8'h7e, 8'hf4, 8'hd0, 8'h0b, 8'he4, 8'hf5,
        8'hcb, 8'hf4, 8'hd7, 8'h00, 8'hfc, 8'hd0, 8'hf3, 8'hab,
        8'h01, 8'h10, 8'hef, 8'h7e, 8'hf4, 8'h10, 8'heb, 8'hba,
        8'hf6, 8'hda, 8'h00, 8'hba, 8'hf4, 8'hc4, 8'hf4, 8'hdd,
        8'h5d, 8'hd0, 8'hdb, 8'h1f, 8'h00, 8'h00, 8'hc0, 8'hff
    };

endpackage

### rtl/core/scio_ram.sv
// ----------------------------------------------------------------------------
// scio_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/sound_cpu_io_timers_block.sv
// ----------------------------------------------------------------------------
// sound_cpu_io_timers_block
// Sound CPU memory and I/O: 64 KB RAM, boot ROM overlay, DSP ports,
// host mailbox ports and three interval timers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel, one transaction per handshake: tuser carries the
//   action (idle, cpu read, cpu write, host port write, host port read),
//   tdata the address, write byte and the DSP register value.
//   Master channel returns exactly one result per transaction: read byte,
//   DSP tick, DSP write strobe, DSP address and DSP write byte.
//   Transactions pass the RAM read stage and output register to master
//   tvalid; one transaction per cycle is sustained while the master does
//   not stall, set by the single RAM port: one read or write per transaction.
//   After reset the RAM is zeroed by a sweep over all 65536 bytes, one byte
//   per cycle; o_s_tready stays low until the sweep ends. All I/O registers
//   and timers reset at once.
//   When the master side stalls, the result held in the output register and
//   one more in the RAM read stage wait; o_s_tready drops until the output
//   register drains. No result is lost or repeated.
// ----------------------------------------------------------------------------
`include "sound_cpu_io_timers_block_defines.svh"

module sound_cpu_io_timers_block (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [15:0] address, [23:16] write_data, [31:24] dsp_read_value
    input  logic [scio_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [2:0] action
    input  logic [scio_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] read_data, [8] dsp_tick, [9] dsp_write_valid,
    // [17:10] dsp_address, [25:18] dsp_write_value, [31:26] zero
    output logic [scio_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import scio_pkg::*;

    // input fields
    t_action           in_action;
    logic [15:0]       in_addr;
    t_byte             in_wdata;
    t_byte             in_dsp_val;
    logic [3:0]        io_reg;
    logic              io_hit;

    // handshake
    logic              accept;
    logic              s1_move;

    // RAM clear sweep
    logic              r_clr_active;
    logic [MEM_AW-1:0] r_clr_addr;

    // I/O state
    t_byte             r_dsp_addr, n_dsp_addr;
    logic              r_rom_vis, n_rom_vis;
    logic [4:0]        r_phase, n_phase;
    t_byte             r_stage [TIMER_COUNT];
    t_byte             n_stage [TIMER_COUNT];
    t_byte             r_div [TIMER_COUNT];
    t_byte             n_div [TIMER_COUNT];
    t_byte             r_target [TIMER_COUNT];
    t_byte             n_target [TIMER_COUNT];
    logic [3:0]        r_cnt [TIMER_COUNT];
    logic [3:0]        n_cnt [TIMER_COUNT];
    logic              r_ten [TIMER_COUNT];
    logic              n_ten [TIMER_COUNT];
    t_byte             r_h2s [6];
    t_byte             n_h2s [6];
    t_byte             r_s2h [4];
    t_byte             n_s2h [4];

    // per-transaction results
    t_byte             rd_val;
    logic              use_mem;
    logic              tick;
    logic              dsp_wr;
    t_byte             div_inc;

    // RAM port
    logic              ram_en;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    t_byte             ram_wdata;
    t_byte             ram_rdata;

    // read stage and output register
    logic              r_s1_valid;
    logic              r_s1_use_mem;
    t_byte             r_s1_rd;
    logic              r_s1_tick;
    logic              r_s1_dwv;
    t_byte             r_s1_daddr;
    t_byte             r_s1_dwval;
    logic              r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    t_byte             s1_read;

    assign in_action  = t_action'(i_s_tuser);
    assign in_addr    = i_s_tdata[15:0];
    assign in_wdata   = i_s_tdata[23:16];
    assign in_dsp_val = i_s_tdata[31:24];
    assign io_reg     = in_addr[3:0];
    assign io_hit     = (in_addr[15:4] == IO_PAGE);

    assign s1_move    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_clr_active && (!r_s1_valid || s1_move);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_dsp_addr = r_dsp_addr;
        n_rom_vis  = r_rom_vis;
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_div      = r_div;
        n_target   = r_target;
        n_cnt      = r_cnt;
        n_ten      = r_ten;
        n_h2s      = r_h2s;
        n_s2h      = r_s2h;
        rd_val     = '0;
        use_mem    = 1'b0;
        tick       = 1'b0;
        dsp_wr     = 1'b0;
        div_inc    = '0;

        if (accept && (in_action == ACT_IDLE || in_action == ACT_CPU_RD ||
                       in_action == ACT_CPU_WR)) begin
            tick    = (r_phase == 5'd0);
            n_phase = r_phase + 5'd1;
            for (int t = 0; t < TIMER_COUNT; t++) begin
                if (r_stage[t] == 8'd0) begin
                    n_stage[t] = TIMER_RELOAD[t];
                    if (r_ten[t]) begin
                        div_inc = r_div[t] + 8'd1;
                        if (div_inc == r_target[t]) begin
                            n_div[t] = '0;
                            n_cnt[t] = r_cnt[t] + 4'd1;
                        end else begin
                            n_div[t] = div_inc;
                        end
                    end
                end else begin
                    n_stage[t] = r_stage[t] - 8'd1;
                end
            end
        end

        if (accept) begin
            case (in_action)
                ACT_CPU_RD: begin
                    if (io_hit) begin
                        case (io_reg)
                            REG_DSP_ADDR: rd_val = r_dsp_addr;
                            REG_DSP_DATA: rd_val = in_dsp_val;
                            REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3,
                            REG_AUX0, REG_AUX1: begin
                                rd_val = r_h2s[3'(io_reg - REG_PORT0)];
                            end
                            REG_COUNTER0, REG_COUNTER1, REG_COUNTER2: begin
                                rd_val = {4'd0, n_cnt[TIMER_IW'(io_reg - REG_COUNTER0)]};
                                n_cnt[TIMER_IW'(io_reg - REG_COUNTER0)] = '0;
                            end
                            default: rd_val = '0;
                        endcase
                    end else if (r_rom_vis && in_addr >= BOOT_ROM_BASE) begin
                        rd_val = BOOT_ROM[in_addr[5:0]];
                    end else begin
                        use_mem = 1'b1;
                    end
                end
                ACT_CPU_WR: begin
                    if (io_hit) begin
                        case (io_reg)
                            REG_CONTROL: begin
                                for (int t = 0; t < TIMER_COUNT; t++) begin
                                    if (!r_ten[t] && in_wdata[t]) begin
                                        n_div[t] = '0;
                                        n_cnt[t] = '0;
                                    end
                                    n_ten[t] = in_wdata[t];
                                end
                                if (in_wdata[4]) begin
                                    n_h2s[0] = '0;
                                    n_h2s[1] = '0;
                                end
                                if (in_wdata[5]) begin
                                    n_h2s[2] = '0;
                                    n_h2s[3] = '0;
                                end
                                n_rom_vis = in_wdata[7];
                            end
                            REG_DSP_ADDR: n_dsp_addr = in_wdata;
                            REG_DSP_DATA: dsp_wr = !r_dsp_addr[7];
                            REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: begin
                                n_s2h[io_reg[1:0]] = in_wdata;
                            end
                            REG_AUX0, REG_AUX1: begin
                                n_h2s[3'(io_reg - REG_PORT0)] = in_wdata;
                            end
                            REG_TARGET0, REG_TARGET1, REG_TARGET2: begin
                                n_target[TIMER_IW'(io_reg - REG_TARGET0)] = in_wdata;
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_HOST_WR: n_h2s[3'(in_addr[1:0])] = in_wdata;
                ACT_HOST_RD: rd_val = r_s2h[in_addr[1:0]];
                default: ;
            endcase
        end
    end

    always_comb begin
        ram_en    = r_clr_active ||
                    (accept && (in_action == ACT_CPU_RD || in_action == ACT_CPU_WR));
        ram_we    = r_clr_active || (accept && in_action == ACT_CPU_WR);
        ram_addr  = r_clr_active ? r_clr_addr : in_addr;
        ram_wdata = r_clr_active ? t_byte'(0) : in_wdata;
    end

    scio_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_dsp_addr   <= '0;
            r_rom_vis    <= 1'b1;
            r_phase      <= '0;
            for (int t = 0; t < TIMER_COUNT; t++) begin
                r_stage[t]  <= '0;
                r_div[t]    <= '0;
                r_target[t] <= '0;
                r_cnt[t]    <= '0;
                r_ten[t]    <= 1'b0;
            end
            for (int p = 0; p < 6; p++) begin
                r_h2s[p] <= '0;
            end
            for (int p = 0; p < 4; p++) begin
                r_s2h[p] <= '0;
            end
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_dsp_addr <= n_dsp_addr;
            r_rom_vis  <= n_rom_vis;
            r_phase    <= n_phase;
            r_stage    <= n_stage;
            r_div      <= n_div;
            r_target   <= n_target;
            r_cnt      <= n_cnt;
            r_ten      <= n_ten;
            r_h2s      <= n_h2s;
            r_s2h      <= n_s2h;
        end
    end

    // read stage: RAM data lands here in the cycle after the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_use_mem <= use_mem;
            r_s1_rd      <= rd_val;
            r_s1_tick    <= tick;
            r_s1_dwv     <= dsp_wr;
            r_s1_daddr   <= n_dsp_addr;
            r_s1_dwval   <= dsp_wr ? in_wdata : t_byte'(0);
        end
    end

    assign s1_read = r_s1_use_mem ? ram_rdata : r_s1_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= {6'd0, r_s1_dwval, r_s1_daddr, r_s1_dwv, r_s1_tick, s1_read};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `SCIO_ASSERT_NOW(a_no_accept_in_clear, r_clr_active, !o_s_tready, "transaction during RAM clear")
    `SCIO_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_move, r_s1_valid && $stable(r_s1_rd), "read stage lost")
    `SCIO_ASSERT_NOW(a_dsp_wr_low, o_m_tvalid && o_m_tdata[9], !o_m_tdata[17], "DSP write at high address")
    `SCIO_ASSERT_NEXT(a_dsp_addr_wr, accept && in_action == ACT_CPU_WR && in_addr == 16'h00F2, r_dsp_addr == $past(in_wdata), "DSP address write missed")

endmodule
